>>> rtl/core/hmt_pkg.sv
package hmt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W   = 32;
  localparam int PORT_W = 16;
  localparam int BEAT_W = 32;
  localparam int TIME_W = 32;
  localparam int KIND_W = 3;
  localparam int CFG_W  = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_UPDATE = 2'd1;
  localparam op_t OP_SWEEP  = 2'd2;
  localparam op_t OP_GOSSIP = 2'd3;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_NONE      = 3'd0;
  localparam kind_t KIND_ADDED     = 3'd1;
  localparam kind_t KIND_UPDATED   = 3'd2;
  localparam kind_t KIND_UNCHANGED = 3'd3;
  localparam kind_t KIND_REMOVED   = 3'd4;
  localparam kind_t KIND_GOSSIP    = 3'd5;
  localparam kind_t KIND_FULL      = 3'd6;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SELF_ID   = 2'd0;
  localparam cfg_idx_t CFG_SELF_PORT = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT   = 2'd2;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd15;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [BEAT_W-1:0] beat;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [BEAT_W-1:0] beat;
  } result_t;

endpackage

>>> rtl/core/heartbeat_membership_table.sv
// The walk reads the slots in turn; an id match ends an insert or update early, an
// insert or update that adds writes the new entry after the walk, and an insert or
// update naming the own id skips the walk. One item at a time: the next transfer is
// taken in the cycle the final result is first offered. The walk reads one slot per
// cycle; output stalls pause it.
// Reset (synchronous, rst_n low): all slots invalid, own heartbeat zero, timeout 15.
module heartbeat_membership_table import hmt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_operation,
  input  logic [ID_W-1:0]   in_member_id,
  input  logic [PORT_W-1:0] in_member_port,
  input  logic [BEAT_W-1:0] in_beat,
  input  logic [TIME_W-1:0] in_now,
  output logic              out_valid,
  input  logic              out_ready,
  output kind_t             out_kind,
  output logic [ID_W-1:0]   out_id,
  output logic [PORT_W-1:0] out_port,
  output logic [BEAT_W-1:0] out_beat,
  output logic              out_last
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_FLUSH} state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [PORT_W-1:0]       port_r, port_nxt;
  logic [BEAT_W-1:0]       beat_r, beat_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [ID_W-1:0]         self_id_r, self_id_nxt;
  logic [PORT_W-1:0]       self_port_r, self_port_nxt;
  logic [TIME_W-1:0]       timeout_r, timeout_nxt;
  logic [BEAT_W-1:0]       own_beat_r, own_beat_nxt;
  logic [TABLE_DEPTH-1:0]  slot_valid_r, slot_valid_nxt;
  logic [CNT_W-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                    ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]        ev_idx_r, ev_idx_nxt;
  logic                    pend_vld_r, pend_vld_nxt;
  result_t                 pend_r, pend_nxt;
  logic                    out_vld_r, out_vld_nxt;
  result_t                 out_r;
  logic                    out_last_r;

  entry_t                  mem [TABLE_DEPTH];
  entry_t                  rd_data_r;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  entry_t                  mem_wd;

  logic                    push;
  result_t                 push_res;
  logic                    push_last;
  logic                    out_free;
  logic                    hit;
  logic                    stall;
  logic                    stop_early;
  logic                    last_slot;
  logic                    newer;
  logic [TIME_W-1:0]       age;
  result_t                 ev_res;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_kind  = out_r.kind;
  assign out_id    = out_r.id;
  assign out_port  = out_r.port;
  assign out_beat  = out_r.beat;
  assign out_last  = out_last_r;

  assign out_free  = !out_vld_r || out_ready;
  assign rd_addr   = rd_cnt_r[IDX_W-1:0];
  assign age       = now_r - rd_data_r.seen;
  assign newer     = beat_r > rd_data_r.beat;
  assign last_slot = (ev_idx_r == IDX_W'(TABLE_DEPTH - 1));

  // evaluation of the slot whose entry just came out of the memory
  always_comb begin
    hit    = 1'b0;
    ev_res = '{kind: KIND_GOSSIP, id: rd_data_r.id, port: rd_data_r.port,
               beat: rd_data_r.beat};
    case (op_r)
      OP_INSERT: begin
        hit         = slot_valid_r[ev_idx_r] && (rd_data_r.id == id_r);
        ev_res.kind = KIND_UNCHANGED;
      end
      OP_UPDATE: begin
        hit = slot_valid_r[ev_idx_r] && (rd_data_r.id == id_r) &&
              (rd_data_r.port == port_r);
        if (newer) begin
          ev_res.kind = KIND_UPDATED;
          ev_res.beat = beat_r;
        end else begin
          ev_res.kind = KIND_UNCHANGED;
        end
      end
      OP_SWEEP: begin
        hit         = slot_valid_r[ev_idx_r] && (age >= timeout_r);
        ev_res.kind = KIND_REMOVED;
      end
      default: begin
        hit         = slot_valid_r[ev_idx_r];
        ev_res.kind = KIND_GOSSIP;
      end
    endcase
  end

  assign stop_early = hit && ((op_r == OP_INSERT) || (op_r == OP_UPDATE));
  // a new result needs the pending one moved out first
  assign stall = ev_vld_r && hit && pend_vld_r && !out_free;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    port_nxt       = port_r;
    beat_nxt       = beat_r;
    now_nxt        = now_r;
    self_id_nxt    = self_id_r;
    self_port_nxt  = self_port_r;
    timeout_nxt    = timeout_r;
    own_beat_nxt   = own_beat_r;
    slot_valid_nxt = slot_valid_r;
    rd_cnt_nxt     = rd_cnt_r;
    ev_vld_nxt     = ev_vld_r;
    ev_idx_nxt     = ev_idx_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = ev_idx_r;
    mem_wd         = '{id: rd_data_r.id, port: rd_data_r.port, beat: beat_r, seen: now_r};
    push           = 1'b0;
    push_res       = pend_r;
    push_last      = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SELF_ID:   self_id_nxt   = cfg_data[ID_W-1:0];
        CFG_SELF_PORT: self_port_nxt = cfg_data[PORT_W-1:0];
        CFG_TIMEOUT:   timeout_nxt   = cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_operation;
          id_nxt       = in_member_id;
          port_nxt     = in_member_port;
          beat_nxt     = in_beat;
          now_nxt      = in_now;
          rd_cnt_nxt   = '0;
          ev_vld_nxt   = 1'b0;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
          case (in_operation)
            OP_INSERT: begin
              if (in_member_id == self_id_r) begin
                pend_nxt     = '{kind: KIND_UNCHANGED, id: self_id_r, port: self_port_r,
                                 beat: own_beat_r};
                pend_vld_nxt = 1'b1;
                state_nxt    = S_FLUSH;
              end
            end
            OP_UPDATE: begin
              // own id: flush with nothing pending gives the "none" result
              if (in_member_id == self_id_r) state_nxt = S_FLUSH;
            end
            OP_GOSSIP: begin
              own_beat_nxt = own_beat_r + BEAT_W'(1);
              pend_nxt     = '{kind: KIND_GOSSIP, id: self_id_r, port: self_port_r,
                               beat: own_beat_r + BEAT_W'(1)};
              pend_vld_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (rd_cnt_r < CNT_W'(TABLE_DEPTH)) begin
            rd_en      = 1'b1;
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
            ev_vld_nxt = 1'b1;
            ev_idx_nxt = rd_cnt_r[IDX_W-1:0];
          end else begin
            ev_vld_nxt = 1'b0;
          end
          if (ev_vld_r && hit) begin
            if (pend_vld_r) push = 1'b1;
            pend_nxt     = ev_res;
            pend_vld_nxt = 1'b1;
            if (op_r == OP_SWEEP) slot_valid_nxt[ev_idx_r] = 1'b0;
            if ((op_r == OP_UPDATE) && newer) mem_we = 1'b1;
          end
          if (ev_vld_r && (stop_early || last_slot)) begin
            if (!stop_early && ((op_r == OP_INSERT) || (op_r == OP_UPDATE)))
              state_nxt = S_FINISH;
            else
              state_nxt = S_FLUSH;
          end
        end
      end
      S_FINISH: begin
        if (free_found) begin
          mem_we                   = 1'b1;
          mem_wa                   = free_idx;
          mem_wd                   = '{id: id_r, port: port_r, beat: beat_r, seen: now_r};
          slot_valid_nxt[free_idx] = 1'b1;
          pend_nxt                 = '{kind: KIND_ADDED, id: id_r, port: port_r,
                                       beat: beat_r};
        end else begin
          pend_nxt = '{kind: KIND_FULL, id: id_r, port: port_r, beat: beat_r};
        end
        pend_vld_nxt = 1'b1;
        state_nxt    = S_FLUSH;
      end
      S_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          push_res     = pend_vld_r ? pend_r
                                    : result_t'{kind: KIND_NONE, id: '0, port: '0,
                                                beat: '0};
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_vld_nxt = push ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      self_id_r    <= '0;
      self_port_r  <= '0;
      timeout_r    <= TIMEOUT_RST;
      own_beat_r   <= '0;
      slot_valid_r <= '0;
      rd_cnt_r     <= '0;
      ev_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      self_id_r    <= self_id_nxt;
      self_port_r  <= self_port_nxt;
      timeout_r    <= timeout_nxt;
      own_beat_r   <= own_beat_nxt;
      slot_valid_r <= slot_valid_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      ev_vld_r     <= ev_vld_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    port_r   <= port_nxt;
    beat_r   <= beat_nxt;
    now_r    <= now_nxt;
    ev_idx_r <= ev_idx_nxt;
    pend_r   <= pend_nxt;
    if (push) begin
      out_r      <= push_res;
      out_last_r <= push_last;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

endmodule

>>> rtl/core/hmt_checker.sv
module hmt_checker import hmt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input kind_t             out_kind,
  input logic [ID_W-1:0]   out_id,
  input logic [PORT_W-1:0] out_port,
  input logic [BEAT_W-1:0] out_beat,
  input logic              out_last
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_id) &&
    $stable(out_port) && $stable(out_beat) && $stable(out_last))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_FULL))
    else $error("result kind out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (.*);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench import hmt_pkg::*;;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 72;
  localparam int DRAIN_WAIT  = TABLE_DEPTH + 8;
  localparam logic [ID_W-1:0] POOL_BASE = 32'h0001_0000;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [BEAT_W-1:0] beat;
    logic              last;
  } member_report_t;

  class membership_scoreboard;
    logic [ID_W-1:0]   self_id;
    logic [PORT_W-1:0] self_port;
    logic [TIME_W-1:0] fail_timeout;
    logic [BEAT_W-1:0] own_beat;
    bit                used  [TABLE_DEPTH];
    logic [ID_W-1:0]   ids   [TABLE_DEPTH];
    logic [PORT_W-1:0] ports [TABLE_DEPTH];
    logic [BEAT_W-1:0] beats [TABLE_DEPTH];
    logic [TIME_W-1:0] seen  [TABLE_DEPTH];
    member_report_t    pending[$];
    int                errors;

    function new();
      self_id      = '0;
      self_port    = '0;
      fail_timeout = TIMEOUT_RST;
      own_beat     = '0;
      errors       = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SELF_ID:   self_id = val;
        CFG_SELF_PORT: self_port = val[PORT_W-1:0];
        CFG_TIMEOUT:   fail_timeout = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void report(kind_t k, logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
                         logic [BEAT_W-1:0] beat);
      member_report_t r;
      r.kind = k;
      r.id   = id;
      r.port = port;
      r.beat = beat;
      r.last = 1'b0;
      pending.insert(pending.size(), r);
    endfunction

    // lowest free slot, or a KIND_FULL report when the table is full
    function void admit(logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
                        logic [BEAT_W-1:0] beat, logic [TIME_W-1:0] now);
      int slot;
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!used[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        report(KIND_FULL, id, port, beat);
      end else begin
        used[slot]  = 1'b1;
        ids[slot]   = id;
        ports[slot] = port;
        beats[slot] = beat;
        seen[slot]  = now;
        report(KIND_ADDED, id, port, beat);
      end
    endfunction

    function void take_message(op_t op, logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
                               logic [BEAT_W-1:0] beat, logic [TIME_W-1:0] now);
      int hit;
      int removed;
      logic [TIME_W-1:0] age;
      hit = -1;
      removed = 0;
      case (op)
        OP_INSERT: begin
          if (id == self_id) begin
            report(KIND_UNCHANGED, self_id, self_port, own_beat);
          end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (used[i] && ids[i] == id) begin
                hit = i;
                break;
              end
            end
            if (hit >= 0) report(KIND_UNCHANGED, ids[hit], ports[hit], beats[hit]);
            else admit(id, port, beat, now);
          end
        end
        OP_UPDATE: begin
          if (id == self_id) begin
            report(KIND_NONE, '0, '0, '0);
          end else begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (used[i] && ids[i] == id && ports[i] == port) begin
                hit = i;
                break;
              end
            end
            if (hit < 0) begin
              admit(id, port, beat, now);
            end else if (beat > beats[hit]) begin
              beats[hit] = beat;
              seen[hit]  = now;
              report(KIND_UPDATED, ids[hit], ports[hit], beats[hit]);
            end else begin
              report(KIND_UNCHANGED, ids[hit], ports[hit], beats[hit]);
            end
          end
        end
        OP_SWEEP: begin
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            age = now - seen[i];
            if (used[i] && age >= fail_timeout) begin
              used[i] = 1'b0;
              report(KIND_REMOVED, ids[i], ports[i], beats[i]);
              removed++;
            end
          end
          if (removed == 0) report(KIND_NONE, '0, '0, '0);
        end
        default: begin
          own_beat = own_beat + 1'b1;
          report(KIND_GOSSIP, self_id, self_port, own_beat);
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (used[i]) report(KIND_GOSSIP, ids[i], ports[i], beats[i]);
          end
        end
      endcase
      pending[pending.size()-1].last = 1'b1;
    endfunction

    // a random live entry, so updates can hit existing members
    function bit pick_live(output logic [ID_W-1:0] id, output logic [PORT_W-1:0] port,
                           output logic [BEAT_W-1:0] beat);
      int n;
      int k;
      n = 0;
      id = '0;
      port = '0;
      beat = '0;
      foreach (used[i]) if (used[i]) n++;
      if (n == 0) return 1'b0;
      k = $urandom_range(0, n - 1);
      foreach (used[i]) begin
        if (used[i]) begin
          if (k == 0) begin
            id = ids[i];
            port = ports[i];
            beat = beats[i];
            return 1'b1;
          end
          k--;
        end
      end
      return 1'b0;
    endfunction

    function void check_result(kind_t kind, logic [ID_W-1:0] id, logic [PORT_W-1:0] port,
                               logic [BEAT_W-1:0] beat, logic last);
      member_report_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d id %h port %h beat %h", kind, id, port, beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        errors++;
      end
      if (id !== want.id) begin
        $error("out_id: expected %h, got %h", want.id, id);
        errors++;
      end
      if (port !== want.port) begin
        $error("out_port: expected %h, got %h", want.port, port);
        errors++;
      end
      if (beat !== want.beat) begin
        $error("out_beat: expected %h, got %h", want.beat, beat);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  op_t               in_operation;
  logic [ID_W-1:0]   in_member_id;
  logic [PORT_W-1:0] in_member_port;
  logic [BEAT_W-1:0] in_beat;
  logic [TIME_W-1:0] in_now;
  logic              out_valid;
  logic              out_ready;
  kind_t             out_kind;
  logic [ID_W-1:0]   out_id;
  logic [PORT_W-1:0] out_port;
  logic [BEAT_W-1:0] out_beat;
  logic              out_last;

  membership_scoreboard sb;
  int                   send_gap_max;
  int                   take_gap_max;
  int                   cycles;
  logic [TIME_W-1:0]    ticks;

  heartbeat_membership_table DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input op_t op, input logic [ID_W-1:0] id,
                           input logic [PORT_W-1:0] port, input logic [BEAT_W-1:0] beat,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_member_id   <= id;
    in_member_port <= port;
    in_beat        <= beat;
    in_now         <= now;
    do @(posedge clk); while (!in_ready);
    sb.take_message(op, id, port, beat, now);
  endtask

  // hold the sender until the table has answered everything
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [ID_W-1:0] id, input logic [PORT_W-1:0] port,
                            input logic [TIME_W-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SELF_ID;
    cfg_data  <= id;
    @(posedge clk);
    sb.set_reg(CFG_SELF_ID, id);
    cfg_index <= CFG_SELF_PORT;
    cfg_data  <= CFG_W'(port);
    @(posedge clk);
    sb.set_reg(CFG_SELF_PORT, CFG_W'(port));
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    sb.set_reg(CFG_TIMEOUT, tmo);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 18;
    endcase
  endfunction

  task automatic random_item();
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [PORT_W-1:0] port;
    logic [BEAT_W-1:0] beat;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   live_id;
    logic [PORT_W-1:0] live_port;
    logic [BEAT_W-1:0] live_beat;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) op = OP_INSERT;
    else if (roll < 70) op = OP_UPDATE;
    else if (roll < 85) op = OP_SWEEP;
    else op = OP_GOSSIP;

    ticks = ticks + $urandom_range(0, 3);
    now = ($urandom_range(0, 19) == 0) ? $urandom : ticks;

    roll = $urandom_range(0, 99);
    if (roll < 8) id = sb.self_id;
    else if (roll < 18) id = $urandom;
    else id = POOL_BASE + $urandom_range(0, 39);
    port = ($urandom_range(0, 9) == 0) ? PORT_W'($urandom) : PORT_W'($urandom_range(0, 3));
    beat = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);

    if (op == OP_UPDATE && $urandom_range(0, 9) < 6 &&
        sb.pick_live(live_id, live_port, live_beat)) begin
      id   = live_id;
      port = live_port;
      beat = live_beat + $urandom_range(0, 4) - 1;
    end
    send_item(op, id, port, beat, now);
  endtask

  // result side: random stall before each transfer, then check it
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, take_gap_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_kind, out_id, out_port, out_beat, out_last);
    end
  end

  initial begin
    logic [ID_W-1:0]   phase_id   [PHASES];
    logic [PORT_W-1:0] phase_port [PHASES];
    logic [TIME_W-1:0] phase_tmo  [PHASES];
    sb = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SELF_ID;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_operation   = OP_INSERT;
    in_member_id   = '0;
    in_member_port = '0;
    in_beat        = '0;
    in_now         = '0;
    send_gap_max   = 0;
    take_gap_max   = 0;
    ticks          = '0;

    phase_id   = '{32'h0000_0000, 32'hFFFF_FFFF, POOL_BASE + 5, $urandom, POOL_BASE + 17};
    phase_port = '{16'h0000, 16'hFFFF, PORT_W'($urandom), 16'h8001, 16'h00FF};
    phase_tmo  = '{32'd1, 32'hFFFF_FFFF, 32'd20, 32'd0, 32'd15};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: own id 0, timeout 15
    send_item(OP_SWEEP, '0, '0, '0, 32'd0);
    send_item(OP_GOSSIP, '0, '0, '0, 32'd0);
    send_item(OP_UPDATE, 32'd0, 16'd0, 32'd7, 32'd0);
    send_item(OP_INSERT, 32'd0, 16'd3, 32'd1, 32'd0);
    send_item(OP_INSERT, POOL_BASE + 1, 16'd1, 32'd3, 32'd0);
    send_item(OP_SWEEP, '0, '0, '0, 32'd15);
    drain();

    write_regs(POOL_BASE + 39, 16'h1234, 32'd40);
    send_item(OP_INSERT, 32'h0, 16'h0, 32'h0, 32'h0);
    send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, POOL_BASE + 39, 16'd9, 32'd9, 32'd1);
    send_item(OP_INSERT, 32'h0, 16'd5, 32'd2, 32'd1);
    send_item(OP_UPDATE, POOL_BASE + 39, 16'h1234, 32'd50, 32'd1);
    send_item(OP_UPDATE, 32'h0, 16'h0, 32'd9, 32'd2);
    send_item(OP_UPDATE, 32'h0, 16'h0, 32'd9, 32'd2);
    send_item(OP_UPDATE, 32'h0, 16'h0, 32'd4, 32'd2);
    // same id, other port: a second entry
    send_item(OP_UPDATE, 32'h0, 16'd7, 32'd1, 32'd3);
    send_item(OP_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd3);
    send_item(OP_GOSSIP, '0, '0, '0, 32'd4);
    send_item(OP_SWEEP, '0, '0, '0, 32'd20);
    send_item(OP_SWEEP, '0, '0, '0, 32'd41);
    send_item(OP_GOSSIP, '0, '0, '0, 32'd41);
    ticks = 32'd41;

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_regs(phase_id[p], phase_port[p], phase_tmo[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 24 == 0) begin
          send_gap_max = pick_gap_max();
          take_gap_max = pick_gap_max();
        end
        if (p == 2 && n == 36) drain();
        random_item();
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
